// ===== rtl/slt_pkg.sv =====
package slt_pkg;

   // list geometry
   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // field widths
   localparam int VALUE_W     = 32;
   localparam int INDEX_W     = 6;
   localparam int ACTION_W    = 2;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 7;
   localparam int CMP_W       = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

   // stream word widths, padded to whole bytes
   localparam int REQ_BITS    = VALUE_W + INDEX_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS    = VALUE_W + STATUS_W + COUNT_OUT_W + 1;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_READ   = 2'd2,
      ACT_CLEAR  = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_RD_WAIT,
      S_INS_RD,
      S_INS_CHK,
      S_REM_RD,
      S_REM_WR,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      RD_IDX,
      RD_PTR_DN,
      RD_PTR_UP
   } rd_sel_type;

   // controller to datapath
   typedef struct packed {
      logic       load_req;
      logic       set_status;
      status_type status;
      logic       cnt_clr;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       ptr_load_cnt;
      logic       ptr_load_idx;
      logic       ptr_inc;
      logic       ptr_dec;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_shift;
      logic       wr_val;
      logic       latch_rd;
      logic       load_rsp;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      action_type act;
      logic       full;
      logic       idx_ok;
      logic       ptr_zero;
      logic       rem_more;
      logic       shift;
      logic       rsp_busy;
   } dp_sts_type;

endpackage

// ===== rtl/slt_ctrl.sv =====
module slt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  slt_pkg::dp_sts_type sts,
   output slt_pkg::dp_cmd_type cmd
);
   import slt_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.status = ST_OK;
      cmd.rd_sel = RD_IDX;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            case (sts.act)
               ACT_INSERT: begin
                  if (sts.full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_FULL;
                     state_in       = S_DONE;
                  end else begin
                     cmd.ptr_load_cnt = 1'b1;
                     state_in         = S_INS_RD;
                  end
               end
               ACT_REMOVE: begin
                  if (!sts.idx_ok) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_RANGE;
                     state_in       = S_DONE;
                  end else begin
                     cmd.ptr_load_idx = 1'b1;
                     state_in         = S_REM_RD;
                  end
               end
               ACT_READ: begin
                  if (!sts.idx_ok) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_RANGE;
                     state_in       = S_DONE;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_IDX;
                     state_in   = S_RD_WAIT;
                  end
               end
               default: begin
                  cmd.cnt_clr = 1'b1;
                  state_in    = S_DONE;
               end
            endcase
         end
         S_RD_WAIT: begin
            cmd.latch_rd = 1'b1;
            state_in     = S_DONE;
         end
         // walk down from the top, moving larger-or-equal entries up one slot
         S_INS_RD: begin
            if (sts.ptr_zero) begin
               cmd.wr_val  = 1'b1;
               cmd.cnt_inc = 1'b1;
               state_in    = S_DONE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_PTR_DN;
               state_in   = S_INS_CHK;
            end
         end
         S_INS_CHK: begin
            if (sts.shift) begin
               cmd.wr_shift = 1'b1;
               cmd.ptr_dec  = 1'b1;
               state_in     = S_INS_RD;
            end else begin
               cmd.wr_val  = 1'b1;
               cmd.cnt_inc = 1'b1;
               state_in    = S_DONE;
            end
         end
         // close the gap by pulling later entries down one slot
         S_REM_RD: begin
            if (sts.rem_more) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_PTR_UP;
               state_in   = S_REM_WR;
            end else begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_DONE;
            end
         end
         S_REM_WR: begin
            cmd.wr_shift = 1'b1;
            cmd.ptr_inc  = 1'b1;
            state_in     = S_REM_RD;
         end
         S_DONE: begin
            if (!sts.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/slt_datapath.sv =====
module slt_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [slt_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic [slt_pkg::ACTION_W-1:0]        req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [slt_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  slt_pkg::dp_cmd_type                 cmd,
   output slt_pkg::dp_sts_type                 sts
);
   import slt_pkg::*;

   // entry storage
   logic [VALUE_W-1:0] mem [CAPACITY];

   action_type                act_ff;
   logic signed [VALUE_W-1:0] val_ff;
   logic [INDEX_W-1:0]        idx_ff;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          ptr_ff;
   logic [VALUE_W-1:0]        rd_data_ff;
   logic [VALUE_W-1:0]        rdv_ff;
   status_type                status_ff;
   logic                      rsp_valid_ff;
   logic [RSP_TDATA_W-1:0]    rsp_data_ff;

   logic [CNT_W-1:0]  ptr_dn;
   logic [CNT_W-1:0]  ptr_up;
   logic [CMP_W-1:0]  idx_ext;
   logic [CMP_W-1:0]  cnt_ext;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;

   assign ptr_dn  = ptr_ff - CNT_W'(1);
   assign ptr_up  = ptr_ff + CNT_W'(1);
   assign idx_ext = CMP_W'(idx_ff);
   assign cnt_ext = CMP_W'(count_ff);
   assign wr_addr = ptr_ff[ADDR_W-1:0];

   // status toward the controller
   always_comb begin
      sts.act      = act_ff;
      sts.full     = (count_ff == CNT_W'(CAPACITY));
      sts.idx_ok   = (idx_ext < cnt_ext);
      sts.ptr_zero = (ptr_ff == '0);
      sts.rem_more = (ptr_up < count_ff);
      sts.shift    = ($signed(rd_data_ff) >= val_ff);
      sts.rsp_busy = rsp_valid_ff && !rsp_tready;
   end

   // read address select
   always_comb begin
      case (cmd.rd_sel)
         RD_IDX:    rd_addr = ADDR_W'(idx_ext);
         RD_PTR_DN: rd_addr = ptr_dn[ADDR_W-1:0];
         RD_PTR_UP: rd_addr = ptr_up[ADDR_W-1:0];
         default:   rd_addr = ptr_ff[ADDR_W-1:0];
      endcase
   end

   // memory ports
   always_ff @(posedge clock) begin
      if (cmd.wr_shift) begin
         mem[wr_addr] <= rd_data_ff;
      end else if (cmd.wr_val) begin
         mem[wr_addr] <= val_ff;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // request word capture
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         act_ff <= action_type'(req_tuser);
         val_ff <= $signed(req_tdata[VALUE_W-1:0]);
         idx_ff <= req_tdata[VALUE_W +: INDEX_W];
      end
   end

   // entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.cnt_clr) begin
         count_ff <= '0;
      end else if (cmd.cnt_inc) begin
         count_ff <= count_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_ff <= count_ff - CNT_W'(1);
      end
   end

   // walking pointer
   always_ff @(posedge clock) begin
      if (cmd.ptr_load_cnt) begin
         ptr_ff <= count_ff;
      end else if (cmd.ptr_load_idx) begin
         ptr_ff <= CNT_W'(idx_ext);
      end else if (cmd.ptr_inc) begin
         ptr_ff <= ptr_up;
      end else if (cmd.ptr_dec) begin
         ptr_ff <= ptr_dn;
      end
   end

   // result fields
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         rdv_ff    <= '0;
         status_ff <= ST_OK;
      end else begin
         if (cmd.set_status) begin
            status_ff <= cmd.status;
         end
         if (cmd.latch_rd) begin
            rdv_ff <= rd_data_ff;
         end
      end
   end

   // response word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_data_ff <= RSP_TDATA_W'({(count_ff == '0),
                                      COUNT_OUT_W'(count_ff),
                                      status_ff,
                                      rdv_ff});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/sorted_list_table.sv =====
// Sorted list table: keeps up to 64 signed 32-bit entries in ascending order
// in a single-port-write, single-port-read memory. Each request word carries
// one action in req_tuser (insert, remove at index, read at index, clear) and
// gives exactly one response word with the read value, a status code, the
// entry count and an empty flag. Words are handled one at a time by a walking
// sequencer around the memory, so the cost of an action follows the number of
// entries it has to move, with one memory read and one write per entry: a
// remove moves count - index - 1 entries, an insert every entry greater than
// or equal to the new value, while clear, read and any rejected action move
// none. A new request word is taken as soon as the previous response is
// loaded into the output register, even while that response still waits for
// rsp_tready; the next word's response is then held in S_DONE until the
// output register is free.
module sorted_list_table (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // value [31:0], index [37:32], zero pad [39:38]
   input  logic [slt_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // action [1:0]
   input  logic [slt_pkg::ACTION_W-1:0]        req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // read_value [31:0], status [33:32], entry_count [40:34], list_empty [41],
   // zero pad [47:42]
   output logic [slt_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);
   import slt_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   slt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   slt_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

// ===== rtl/slt_checker.sv =====
module slt_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [slt_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input logic [slt_pkg::ACTION_W-1:0]        req_tuser,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [slt_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);
   import slt_pkg::*;

   logic [VALUE_W-1:0]     rsp_value;
   logic [STATUS_W-1:0]    rsp_status;
   logic [COUNT_OUT_W-1:0] rsp_count;
   logic                   rsp_empty;

   assign rsp_value  = rsp_tdata[VALUE_W-1:0];
   assign rsp_status = rsp_tdata[VALUE_W +: STATUS_W];
   assign rsp_count  = rsp_tdata[VALUE_W + STATUS_W +: COUNT_OUT_W];
   assign rsp_empty  = rsp_tdata[VALUE_W + STATUS_W + COUNT_OUT_W];

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");

   // no status code beyond full
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_status == ST_OK || rsp_status == ST_RANGE ||
                      rsp_status == ST_FULL))
      else $error("unknown status code");

   // empty flag tracks the count
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_empty == (rsp_count == '0)))
      else $error("empty flag disagrees with entry count");

   // failed actions return no value
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_status != ST_OK) |-> (rsp_value == '0))
      else $error("read value set on a failed action");

   // no response is raised while the sequencer decodes a word accepted with none pending
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("response appeared one cycle after an accepted word");

endmodule

bind sorted_list_table slt_checker u_slt_checker (.*);
